// ===== rtl/core/epg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epg_pkg
// shared types, widths and helpers for the ellipse point gate
// ----------------------------------------------------------------------------
package epg_pkg;

  localparam int unsigned IDX_W   = 12;  // keypoint row number
  localparam int unsigned CRD_W   = 16;  // Q12.4 coordinate
  localparam int unsigned INV_W   = 32;  // Q8.24 inverse covariance entry
  localparam int unsigned RAD_W   = 16;  // Q8.8 radius and distance
  localparam int unsigned RSQ_W   = 2 * RAD_W;
  localparam int unsigned DIF_W   = CRD_W + 1;       // point minus centre
  localparam int unsigned SQ_W    = 2 * DIF_W - 1;   // nonnegative square
  localparam int unsigned CR_W    = 2 * DIF_W;       // signed cross product
  localparam int unsigned TRM_W   = CR_W + INV_W;    // weighted term
  localparam int unsigned SUM_W   = TRM_W + 2;       // sum of three terms
  localparam int unsigned FRM_W   = SUM_W - 2;       // clamped form magnitude
  localparam int unsigned ROOT_W  = 32;              // root operand width
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SQRT_STEPS = ROOT_W / 2;
  localparam int unsigned SQRT_PER_STAGE = 2;
  localparam int unsigned SQRT_STAGES = SQRT_STEPS / SQRT_PER_STAGE;

  localparam logic signed [CRD_W-1:0] CENTER_X_RST = '0;
  localparam logic signed [CRD_W-1:0] CENTER_Y_RST = '0;
  localparam logic signed [INV_W-1:0] INV_XX_RST   = 32'sh0100_0000;
  localparam logic signed [INV_W-1:0] INV_XY_RST   = '0;
  localparam logic signed [INV_W-1:0] INV_YY_RST   = 32'sh0100_0000;
  localparam logic [RSQ_W-1:0]        RAD_SQ_RST   = 32'h0001_0000;  // 1.0 squared

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_INV_XX      = 3'd2,
    REG_INV_XY      = 3'd3,
    REG_INV_YY      = 3'd4,
    REG_GATE_RADIUS = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [CRD_W-1:0] center_x;
    logic signed [CRD_W-1:0] center_y;
    logic signed [INV_W-1:0] inv_xx;
    logic signed [INV_W-1:0] inv_xy;
    logic signed [INV_W-1:0] inv_yy;
    logic [RSQ_W-1:0]        rad_sq;
  } cfg_t;

  // keypoint fields that ride along with the arithmetic
  typedef struct packed {
    logic [IDX_W-1:0]        index;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic                    last;
  } meta_t;

  typedef struct packed {
    meta_t                   meta;
    logic signed [TRM_W-1:0] txx;
    logic signed [TRM_W-1:0] txy;  // not yet doubled
    logic signed [TRM_W-1:0] tyy;
  } terms_t;

  typedef struct packed {
    meta_t              meta;
    logic               in_gate;
    logic               sat;
    logic [ROOT_W-1:0]  rad;
  } root_in_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [ROOT_W-1:0] res;
  } sqrt_t;

  typedef struct packed {
    meta_t             meta;
    logic              in_gate;
    logic              sat;
    sqrt_t             sq;
  } root_st_t;

  typedef struct packed {
    meta_t             meta;
    logic              in_gate;
    logic [RAD_W-1:0]  distance;
  } result_t;

  // one restoring square root step, b is the current trial bit
  function automatic sqrt_t sqrt_step(sqrt_t s, logic [ROOT_W-1:0] b);
    sqrt_t r;
    logic [ROOT_W:0] t;
    t = {1'b0, s.res} + {1'b0, b};
    if ({1'b0, s.rem} >= t) begin
      r.rem = s.rem - t[ROOT_W-1:0];
      r.res = (s.res >> 1) + b;
    end else begin
      r.rem = s.rem;
      r.res = s.res >> 1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ellipse_point_gate_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_point_gate_top
// mahalanobis distance gate for 2-d keypoints against a configured ellipse
// ----------------------------------------------------------------------------
// Each keypoint transaction gives exactly one result transaction, in order.
// The block takes one keypoint per clock while no stall reaches the input.
// Its registered stages compute the offsets, squares and inverse covariance
// weighting, then the sum of the quadratic form, then the clamp and radius
// compare, and last the square root, which settles two distance bits per
// stage. Stages hold their item when the next one is full and not taking
// one, so bubbles close up and input keeps flowing while a result waits on
// the output until every stage is full. The inside flag comes from an exact
// compare of the form against the radius squared; the distance, the truncated
// root in Q8.8, saturates at all ones. A negative form (indefinite matrix)
// counts as zero. Configuration writes are always accepted and take effect at
// once, so they belong in idle periods; unknown register indexes are ignored.
// ----------------------------------------------------------------------------
module ellipse_point_gate_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [epg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [epg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // keypoint stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [47:0]                        s_axis_tdata,  // point_index, point_x, point_y
  input  logic                               s_axis_tlast,  // last_point
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [63:0]                        m_axis_tdata,  // out_index, out_x, out_y, distance
  output logic                               m_axis_tuser,  // inside_res
  output logic                               m_axis_tlast   // last_result
);
  import epg_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  meta_t    in_meta;
  terms_t   terms;
  root_in_t root_in;
  result_t  res;
  logic     form_valid, form_ready;
  logic     acc_valid, acc_ready;
  logic [RAD_W-1:0] radius;

  // register file, radius is kept squared for the compare
  assign cfg_ready_o = 1'b1;
  assign radius      = cfg_data_i[RAD_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_CENTER_X:    cfg_d.center_x = cfg_data_i[CRD_W-1:0];
        REG_CENTER_Y:    cfg_d.center_y = cfg_data_i[CRD_W-1:0];
        REG_INV_XX:      cfg_d.inv_xx   = cfg_data_i[INV_W-1:0];
        REG_INV_XY:      cfg_d.inv_xy   = cfg_data_i[INV_W-1:0];
        REG_INV_YY:      cfg_d.inv_yy   = cfg_data_i[INV_W-1:0];
        REG_GATE_RADIUS: cfg_d.rad_sq   = RSQ_W'(radius) * RSQ_W'(radius);
        default:         cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x <= CENTER_X_RST;
      cfg_q.center_y <= CENTER_Y_RST;
      cfg_q.inv_xx   <= INV_XX_RST;
      cfg_q.inv_xy   <= INV_XY_RST;
      cfg_q.inv_yy   <= INV_YY_RST;
      cfg_q.rad_sq   <= RAD_SQ_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // unpack the keypoint
  always_comb begin
    in_meta.index = s_axis_tdata[IDX_W-1:0];
    in_meta.x     = s_axis_tdata[IDX_W+CRD_W-1:IDX_W];
    in_meta.y     = s_axis_tdata[IDX_W+2*CRD_W-1:IDX_W+CRD_W];
    in_meta.last  = s_axis_tlast;
  end

  // offsets, squares and weighting
  epg_form u_form (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (in_meta),
    .out_valid_o (form_valid),
    .out_ready_i (form_ready),
    .out_data_o  (terms)
  );

  // quadratic form, clamp, gate compare
  epg_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (form_valid),
    .in_ready_o  (form_ready),
    .in_data_i   (terms),
    .out_valid_o (acc_valid),
    .out_ready_i (acc_ready),
    .out_data_o  (root_in)
  );

  // distance, last stage doubles as the output register
  epg_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (acc_valid),
    .in_ready_o  (acc_ready),
    .in_data_i   (root_in),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  // pack the result
  assign m_axis_tdata = {4'h0, res.distance, res.meta.y, res.meta.x, res.meta.index};
  assign m_axis_tuser = res.in_gate;
  assign m_axis_tlast = res.meta.last;

endmodule

// ===== rtl/core/epg_form.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epg_form
// three-stage front end: offsets, squares, weighting by inverse covariance
// ----------------------------------------------------------------------------
module epg_form (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  epg_pkg::cfg_t   cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  epg_pkg::meta_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output epg_pkg::terms_t out_data_o
);
  import epg_pkg::*;

  logic [2:0] v_q;
  logic [2:0] en;

  meta_t                   m1_q, m2_q;
  logic signed [DIF_W-1:0] dx_q, dy_q;
  logic [SQ_W-1:0]         sxx_q, syy_q;
  logic signed [CR_W-1:0]  sxy_q;
  terms_t                  t_q;

  logic signed [CR_W-1:0]  pxx, pyy, pxy;
  logic signed [TRM_W-1:0] wxx, wxy, wyy;

  assign en[2] = !v_q[2] || out_ready_i;
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];
  assign in_ready_o = en[0];

  always_comb begin
    pxx = dx_q * dx_q;
    pyy = dy_q * dy_q;
    pxy = CR_W'(dx_q) * CR_W'(dy_q);
    wxx = $signed({1'b0, sxx_q}) * cfg_i.inv_xx;
    wyy = $signed({1'b0, syy_q}) * cfg_i.inv_yy;
    wxy = sxy_q * cfg_i.inv_xy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      m1_q <= in_data_i;
      dx_q <= {in_data_i.x[CRD_W-1], in_data_i.x} - {cfg_i.center_x[CRD_W-1], cfg_i.center_x};
      dy_q <= {in_data_i.y[CRD_W-1], in_data_i.y} - {cfg_i.center_y[CRD_W-1], cfg_i.center_y};
    end
    if (en[1] && v_q[0]) begin
      m2_q  <= m1_q;
      sxx_q <= pxx[SQ_W-1:0];  // a square is never negative
      syy_q <= pyy[SQ_W-1:0];
      sxy_q <= pxy;
    end
    if (en[2] && v_q[1]) begin
      t_q.meta <= m2_q;
      t_q.txx  <= wxx;
      t_q.txy  <= wxy;
      t_q.tyy  <= wyy;
    end
  end

  assign out_valid_o = v_q[2];
  assign out_data_o  = t_q;

endmodule

// ===== rtl/core/epg_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epg_accum
// two stages: sum of the weighted terms, then clamp and exact gate compare
// ----------------------------------------------------------------------------
module epg_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  epg_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  epg_pkg::terms_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output epg_pkg::root_in_t  out_data_o
);
  import epg_pkg::*;

  logic [1:0] v_q;
  logic [1:0] en;

  meta_t                   m_q;
  logic signed [SUM_W-1:0] sum_q;
  root_in_t                r_q;

  logic signed [SUM_W-1:0] sum_d;
  logic [FRM_W-1:0]        form;
  logic [FRM_W-1:0]        lim;

  assign en[1] = !v_q[1] || out_ready_i;
  assign en[0] = !v_q[0] || en[1];
  assign in_ready_o = en[0];

  always_comb begin
    sum_d = {{2{in_data_i.txx[TRM_W-1]}}, in_data_i.txx}
          + {in_data_i.txy[TRM_W-1], in_data_i.txy, 1'b0}
          + {{2{in_data_i.tyy[TRM_W-1]}}, in_data_i.tyy};
    // indefinite matrix can make the form negative: clamp to zero
    form  = sum_q[SUM_W-1] ? '0 : sum_q[FRM_W-1:0];
    lim   = {{(FRM_W-RSQ_W-16){1'b0}}, cfg_i.rad_sq, 16'h0000};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      m_q   <= in_data_i.meta;
      sum_q <= sum_d;
    end
    if (en[1] && v_q[0]) begin
      r_q.meta    <= m_q;
      r_q.in_gate <= (form <= lim);
      r_q.sat     <= |form[FRM_W-1:ROOT_W+16];
      r_q.rad     <= form[ROOT_W+15:16];
    end
  end

  assign out_valid_o = v_q[1];
  assign out_data_o  = r_q;

endmodule

// ===== rtl/core/epg_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epg_sqrt
// pipelined integer square root, two result bits per stage
// ----------------------------------------------------------------------------
module epg_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  epg_pkg::root_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output epg_pkg::result_t   out_data_o
);
  import epg_pkg::*;

  logic [SQRT_STAGES-1:0] v_q;
  logic [SQRT_STAGES-1:0] en;
  root_st_t               st_q [SQRT_STAGES];
  root_st_t               st_in [SQRT_STAGES];
  root_st_t               st_d [SQRT_STAGES];
  root_st_t               last_st;

  always_comb begin
    en[SQRT_STAGES-1] = !v_q[SQRT_STAGES-1] || out_ready_i;
    for (int s = SQRT_STAGES - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end
  assign in_ready_o = en[0];

  always_comb begin
    st_in[0].meta    = in_data_i.meta;
    st_in[0].in_gate = in_data_i.in_gate;
    st_in[0].sat     = in_data_i.sat;
    st_in[0].sq.rem  = in_data_i.rad;
    st_in[0].sq.res  = '0;
    for (int s = 1; s < SQRT_STAGES; s++) begin
      st_in[s] = st_q[s-1];
    end
    for (int s = 0; s < SQRT_STAGES; s++) begin
      st_d[s] = st_in[s];
      for (int k = 0; k < SQRT_PER_STAGE; k++) begin
        st_d[s].sq = sqrt_step(st_d[s].sq,
          ROOT_W'(1) << (ROOT_W - 2 - 2 * (s * SQRT_PER_STAGE + k)));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < SQRT_STAGES; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) st_q[0] <= st_d[0];
    for (int s = 1; s < SQRT_STAGES; s++) begin
      if (en[s] && v_q[s-1]) st_q[s] <= st_d[s];
    end
  end

  assign last_st = st_q[SQRT_STAGES-1];

  always_comb begin
    out_data_o.meta     = last_st.meta;
    out_data_o.in_gate  = last_st.in_gate;
    out_data_o.distance = last_st.sat ? '1 : last_st.sq.res[RAD_W-1:0];
  end
  assign out_valid_o = v_q[SQRT_STAGES-1];

endmodule
